@@ hw/rtl/cdd_pkg.sv @@
// Shared types, constants and calendar tables for the date difference block.
`default_nettype none

package cdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DNUM_W   = 23;
	localparam int DIFF_W   = 22;
	localparam int ORDER_W  = 2;
	localparam int CENT_W   = 8;
	localparam int BDAYS_W  = 9;

	// Reciprocal of 100 scaled by 2**24, exact for all operands below 2**17.
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 24;
	localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

	localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

	localparam logic [ORDER_W-1:0] ORDER_EQUAL = 2'd0;
	localparam logic [ORDER_W-1:0] ORDER_LATER = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} cdd_stage_en_t;

	function automatic logic [BDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
		logic [BDAYS_W-1:0] days;
		unique case (month)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] len;
		unique case (month)
			4'd2:                       len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:         len = 5'd31;
			default:                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/calendar_date_difference.sv @@
// Top level: pipelined day count between two Gregorian dates.
//
//   channel  direction  word
//   s_*      in         two dates (day, month, year each)
//   m_*      out        day difference, order, two validity flags
//
// Four register stages: century count, validity and year terms, day numbers,
// then difference and output register. One word can enter every cycle while
// the pipeline is not held full by a stall on m_tready.
// Reset clears the stage valid bits only.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up under a stall on m_tready and nothing is dropped or repeated.
`default_nettype none

module calendar_date_difference (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// first_day, first_month, first_year, second_day, second_month, second_year, pad
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// day_difference, order, first_valid, second_valid, pad
	output logic      [31:0] m_tdata
);
	import cdd_pkg::*;

	localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;

	logic [DAY_W-1:0]   first_day;
	logic [MONTH_W-1:0] first_month;
	logic [YEAR_W-1:0]  first_year;
	logic [DAY_W-1:0]   second_day;
	logic [MONTH_W-1:0] second_month;
	logic [YEAR_W-1:0]  second_year;
	logic [KEY_W-1:0]   first_key;
	logic [KEY_W-1:0]   second_key;

	cdd_stage_en_t      en;
	logic               en_s4;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [ORDER_W-1:0] order_s1, order_s2, order_s3, order_s4;

	logic [DNUM_W-1:0]  first_num_s3, second_num_s3;
	logic               first_valid_s3, second_valid_s3;
	logic [DNUM_W-1:0]  abs_diff;
	logic [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]  diff_s4;
	logic               first_valid_s4, second_valid_s4;

	assign first_day    = s_tdata[4:0];
	assign first_month  = s_tdata[8:5];
	assign first_year   = s_tdata[22:9];
	assign second_day   = s_tdata[27:23];
	assign second_month = s_tdata[31:28];
	assign second_year  = s_tdata[45:32];

	assign en_s4    = !vld_s4 || m_tready;
	assign en.s3    = !vld_s3 || en_s4;
	assign en.s2    = !vld_s2 || en.s3;
	assign en.s1    = !vld_s1 || en.s2;
	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// Order is the raw comparison of year, month and day, valid or not.
	assign first_key  = {first_year, first_month, first_day};
	assign second_key = {second_year, second_month, second_day};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			if (first_key == second_key) begin
				order_s1 <= ORDER_EQUAL;
			end else if (first_key > second_key) begin
				order_s1 <= ORDER_LATER;
			end else begin
				order_s1 <= ORDER_EARLIER;
			end
		end
		if (en.s2) order_s2 <= order_s1;
		if (en.s3) order_s3 <= order_s2;
	end

	cdd_date_pipe u_first (
		.clk        (clk),
		.en         (en),
		.day        (first_day),
		.month      (first_month),
		.year       (first_year),
		.day_num_s3 (first_num_s3),
		.valid_s3   (first_valid_s3)
	);

	cdd_date_pipe u_second (
		.clk        (clk),
		.en         (en),
		.day        (second_day),
		.month      (second_month),
		.year       (second_year),
		.day_num_s3 (second_num_s3),
		.valid_s3   (second_valid_s3)
	);

	always_comb begin
		if (first_num_s3 > second_num_s3) begin
			abs_diff = first_num_s3 - second_num_s3;
		end else begin
			abs_diff = second_num_s3 - first_num_s3;
		end
		priority if (!(first_valid_s3 && second_valid_s3)) begin
			diff = '0;
		end else if (abs_diff > DNUM_W'(DIFF_MAX)) begin
			diff = DIFF_MAX;
		end else begin
			diff = abs_diff[DIFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			diff_s4         <= diff;
			order_s4        <= order_s3;
			first_valid_s4  <= first_valid_s3;
			second_valid_s4 <= second_valid_s3;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {6'd0, second_valid_s4, first_valid_s4, order_s4, diff_s4};

endmodule

`default_nettype wire

@@ hw/rtl/cdd_date_pipe.sv @@
// Three-stage pipeline that checks one date and turns it into a day number.
`default_nettype none

module cdd_date_pipe (
	input  wire logic                         clk,
	input  wire cdd_pkg::cdd_stage_en_t       en,
	input  wire logic [cdd_pkg::DAY_W-1:0]    day,
	input  wire logic [cdd_pkg::MONTH_W-1:0]  month,
	input  wire logic [cdd_pkg::YEAR_W-1:0]   year,
	output logic      [cdd_pkg::DNUM_W-1:0]   day_num_s3,
	output logic                              valid_s3
);
	import cdd_pkg::*;

	localparam int PROD_W = YEAR_W + RECIP_W;

	logic [PROD_W-1:0]  cent_prod;
	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [CENT_W-1:0]  cent_s1;

	logic [YEAR_W-1:0]  cent_rem;
	logic               rem_nz;
	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               month_ok;

	logic [DAY_W-1:0]   day_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [CENT_W-1:0]  cent_s2;
	logic [DNUM_W-1:0]  y365_s2;
	logic [YEAR_W-2:0]  ceil4_s2;
	logic               rem_nz_s2;
	logic               adj400_s2;
	logic               leap_s2;
	logic               valid_s2;

	logic [DNUM_W-1:0]  year_days;
	logic [DNUM_W-1:0]  day_num;

	// The century count comes from a reciprocal multiply of the year.
	assign cent_prod = PROD_W'(year) * PROD_W'(RECIP_100);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			cent_s1  <= cent_prod[RECIP_SHIFT +: CENT_W];
		end
	end

	always_comb begin
		cent_rem = year_s1 - YEAR_W'(YEAR_W'(cent_s1) * YEAR_W'(100));
		rem_nz   = (cent_rem != '0);
		leap     = (year_s1[1:0] == 2'b00) && (rem_nz || (cent_s1[1:0] == 2'b00));
		month_ok = (month_s1 >= MONTH_JAN) && (month_s1 <= MONTH_DEC);
		len      = month_length(month_s1);
		if (month_s1 == MONTH_FEB && leap) begin
			len = 5'd29;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			day_s2    <= day_s1;
			month_s2  <= month_s1;
			cent_s2   <= cent_s1;
			y365_s2   <= DNUM_W'(year_s1) * DNUM_W'(365);
			ceil4_s2  <= (YEAR_W-1)'((YEAR_W+1)'(year_s1) + (YEAR_W+1)'(3) >> 2);
			rem_nz_s2 <= rem_nz;
			adj400_s2 <= rem_nz || (cent_s1[1:0] != 2'b00);
			leap_s2   <= leap;
			valid_s2  <= month_ok && (day_s1 != '0) && (day_s1 <= len);
		end
	end

	// Year part: 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400).
	always_comb begin
		year_days = y365_s2 + DNUM_W'(ceil4_s2) + DNUM_W'(cent_s2[CENT_W-1:2])
			+ DNUM_W'(adj400_s2) - DNUM_W'(cent_s2) - DNUM_W'(rem_nz_s2);
		day_num = year_days + DNUM_W'(days_before_month(month_s2))
			+ DNUM_W'(leap_s2 && (month_s2 > MONTH_FEB)) + DNUM_W'(day_s2);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			day_num_s3 <= day_num;
			valid_s3   <= valid_s2;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/calendar_date_difference_tb.sv @@
// Self-checking testbench for the Gregorian date difference block.
`default_nettype none

module calendar_date_difference_tb;

	import cdd_pkg::*;

	localparam int N_PHASES = 3;
	localparam int TX_IDLE_PCT [N_PHASES] = '{6, 66, 0};
	localparam int RX_IDLE_PCT [N_PHASES] = '{66, 6, 0};
	localparam int WORDS_PER_PHASE = 310;
	localparam int LONG_STALL = 80;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cal_date_t;

	typedef struct packed {
		logic [DIFF_W-1:0]  days;
		logic [ORDER_W-1:0] order;
		logic               first_ok;
		logic               second_ok;
	} span_t;

	typedef struct {
		cal_date_t first;
		cal_date_t second;
		bit        typed;
		span_t     want;
	} date_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	span_t     pending_spans [$];
	date_row_t date_rows [$];
	int        error_count = 0;
	int        quiet_cycles = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	bit        long_stall_req = 1'b0;

	calendar_date_difference u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(input int m, input int y);
		int len;
		if (m < 1 || m > 12) begin
			return 0;
		end
		len = MONTH_LEN[m];
		if (m == int'(MONTH_FEB) && leap_year(y)) begin
			len = len + 1;
		end
		return len;
	endfunction

	function automatic bit date_ok(input cal_date_t dt);
		return dt.day >= 1 && int'(dt.day) <= month_days(dt.month, dt.year);
	endfunction

	// Days since the start of year 0, which counts as a leap year.
	function automatic int day_index(input cal_date_t dt);
		int y;
		int n;
		y = dt.year;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int m = 1; m < int'(dt.month); m++) begin
			n = n + month_days(m, y);
		end
		return n + dt.day;
	endfunction

	function automatic span_t calc_span(input cal_date_t a, input cal_date_t b);
		span_t r;
		int na;
		int nb;
		int diff;
		r.first_ok = date_ok(a);
		r.second_ok = date_ok(b);
		if ({a.year, a.month, a.day} == {b.year, b.month, b.day}) begin
			r.order = ORDER_EQUAL;
		end else if ({a.year, a.month, a.day} > {b.year, b.month, b.day}) begin
			r.order = ORDER_LATER;
		end else begin
			r.order = ORDER_EARLIER;
		end
		r.days = '0;
		if (r.first_ok && r.second_ok) begin
			na = day_index(a);
			nb = day_index(b);
			diff = (na > nb) ? na - nb : nb - na;
			r.days = (diff > int'(DIFF_MAX)) ? DIFF_MAX : diff[DIFF_W-1:0];
		end
		return r;
	endfunction

	function automatic cal_date_t mk_date(input int d, input int m, input int y);
		cal_date_t dt;
		dt.day = d[DAY_W-1:0];
		dt.month = m[MONTH_W-1:0];
		dt.year = y[YEAR_W-1:0];
		return dt;
	endfunction

	// Mostly real dates with random content; some raw field noise and dates just past
	// the end of their month.
	function automatic cal_date_t rand_date();
		cal_date_t dt;
		int pick;
		int y;
		int m;
		int len;
		int r;
		pick = $urandom_range(99);
		if (pick < 12) begin
			dt.day = DAY_W'($urandom_range(31));
			dt.month = MONTH_W'($urandom_range(15));
			dt.year = YEAR_W'($urandom_range(16383));
			return dt;
		end
		if (pick < 20) begin
			y = $urandom_range(16383, 10000);
		end else if (pick < 30) begin
			y = $urandom_range(99) * 100;
		end else begin
			y = $urandom_range(9999);
		end
		m = $urandom_range(12, 1);
		len = month_days(m, y);
		r = $urandom_range(9);
		if (r == 0) begin
			dt = mk_date(len + 1, m, y);
		end else if (r == 1) begin
			dt = mk_date(len, m, y);
		end else begin
			dt = mk_date($urandom_range(len, 1), m, y);
		end
		return dt;
	endfunction

	task automatic add_row(input int d1, input int m1, input int y1, input int d2,
			input int m2, input int y2, input bit typed, input int days,
			input logic [ORDER_W-1:0] ord, input bit v1, input bit v2);
		date_row_t row;
		row.first = mk_date(d1, m1, y1);
		row.second = mk_date(d2, m2, y2);
		row.typed = typed;
		row.want.days = days[DIFF_W-1:0];
		row.want.order = ord;
		row.want.first_ok = v1;
		row.want.second_ok = v2;
		date_rows.push_back(row);
	endtask

	task automatic send_dates(input cal_date_t a, input cal_date_t b, input span_t want);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, b.year, b.month, b.day, a.year, a.month, a.day};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pending_spans.push_back(want);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic flag_mismatch(input string field, input int want, input int got);
		$display("MISMATCH %s: expected %0d, got %0d", field, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		span_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_spans.size() == 0) begin
				flag_mismatch("unexpected word", 0, int'(m_tdata));
			end else begin
				want = pending_spans.pop_front();
				if (m_tdata[21:0] != want.days) begin
					flag_mismatch("day_difference", want.days, m_tdata[21:0]);
				end
				if (m_tdata[23:22] != want.order) begin
					flag_mismatch("order", want.order, m_tdata[23:22]);
				end
				if (m_tdata[24] != want.first_ok) begin
					flag_mismatch("first_valid", want.first_ok, m_tdata[24]);
				end
				if (m_tdata[25] != want.second_ok) begin
					flag_mismatch("second_valid", want.second_ok, m_tdata[25]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		cal_date_t a;
		cal_date_t b;
		int pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;

		add_row( 1,  1,  2000,  1,  1,  2000, 1, 0, ORDER_EQUAL, 1, 1);
		add_row( 0,  0,     0,  0,  0,     0, 1, 0, ORDER_EQUAL, 0, 0);
		add_row(31, 15, 16383, 31, 15, 16383, 1, 0, ORDER_EQUAL, 0, 0);
		add_row( 1,  1,     0, 31, 12, 16383, 1, DIFF_MAX, ORDER_EARLIER, 1, 1);
		add_row(31, 12, 16383,  1,  1,     0, 1, DIFF_MAX, ORDER_LATER, 1, 1);
		add_row(29,  2,  2000,  1,  3,  2000, 1, 1, ORDER_EARLIER, 1, 1);
		add_row(29,  2,  1900,  1,  1,  1900, 1, 0, ORDER_LATER, 0, 1);
		add_row(29,  2,  2023, 28,  2,  2023, 1, 0, ORDER_LATER, 0, 1);
		add_row(31,  4,  2020, 30,  4,  2020, 1, 0, ORDER_LATER, 0, 1);
		add_row( 0,  5,  2020,  1,  5,  2020, 1, 0, ORDER_EARLIER, 0, 1);
		add_row(15, 13,  2020, 15, 12,  2020, 1, 0, ORDER_LATER, 0, 1);
		add_row( 1,  1,  2021, 31, 12,  2020, 1, 1, ORDER_LATER, 1, 1);
		add_row(31, 12,  1999,  1,  1,  2000, 1, 1, ORDER_EARLIER, 1, 1);
		add_row(29,  2,     0,  1,  3,     0, 1, 1, ORDER_EARLIER, 1, 1);
		add_row( 1,  3,  2000,  1,  3,  2001, 1, 365, ORDER_EARLIER, 1, 1);
		add_row( 1,  1,  2001,  1,  1,  2000, 1, 366, ORDER_LATER, 1, 1);
		add_row(31,  1,  2022,  1,  2,  2022, 1, 1, ORDER_EARLIER, 1, 1);
		add_row( 5,  0,   100, 31, 15,    99, 1, 0, ORDER_LATER, 0, 0);
		add_row( 1,  1,  2000,  0,  1,  2000, 1, 0, ORDER_LATER, 1, 0);
		add_row( 1,  1,     0, 31, 12,  9999, 0, 0, ORDER_EQUAL, 0, 0);
		add_row(29,  2,  2024, 28,  2,  2023, 0, 0, ORDER_EQUAL, 0, 0);
		add_row( 1,  1,  9999, 31, 12,  9999, 0, 0, ORDER_EQUAL, 0, 0);
		add_row(31, 12, 16383,  1,  1, 10000, 0, 0, ORDER_EQUAL, 0, 0);
		add_row(29,  2,  2400, 29,  2,  1600, 0, 0, ORDER_EQUAL, 0, 0);
		add_row(31, 12, 10000,  1,  1,     0, 0, 0, ORDER_EQUAL, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = TX_IDLE_PCT[0];
		rx_idle_pct = RX_IDLE_PCT[0];
		@(posedge clk);

		foreach (date_rows[i]) begin
			send_dates(date_rows[i].first, date_rows[i].second,
				date_rows[i].typed ? date_rows[i].want
					: calc_span(date_rows[i].first, date_rows[i].second));
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			tx_idle_pct = TX_IDLE_PCT[phase];
			rx_idle_pct = RX_IDLE_PCT[phase];
			if (phase == N_PHASES - 1) begin
				long_stall_req = 1'b1;
			end
			repeat (WORDS_PER_PHASE) begin
				a = rand_date();
				pick = $urandom_range(99);
				if (pick < 10) begin
					b = a;
				end else if (pick < 30) begin
					b = rand_date();
					b.year = a.year;
				end else begin
					b = rand_date();
				end
				send_dates(a, b, calc_span(a, b));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_spans.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
